// ----- rtl/pwenv_pkg.sv -----
// Shared types, constants and lookup functions for the piecewise envelope evaluator.
// No dependencies; every other file refers to it by scoped names.
package pwenv_pkg;

   localparam int MAX_POINTS = 64;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = 7;

   localparam logic [16:0] Q_ONE  = 17'h10000;
   localparam logic [16:0] Q_HALF = 17'h08000;

   // request commands
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_EVAL  = 1'b1;

   // segment modes
   localparam logic [2:0] MODE_HOLD   = 3'd0;
   localparam logic [2:0] MODE_SINGLE = 3'd1;
   localparam logic [2:0] MODE_DOUBLE = 3'd2;
   localparam logic [2:0] MODE_SAW    = 3'd3;
   localparam logic [2:0] MODE_PULSE  = 3'd4;
   localparam logic [2:0] MODE_STEPS  = 3'd5;

   typedef struct packed {
      logic               command;
      logic [5:0]         point_index;
      logic signed [31:0] point_x;
      logic [16:0]        point_y;
      logic [2:0]         point_mode;
      logic signed [11:0] point_tweak;
      logic signed [31:0] sample_time;
   } req_type;

   typedef struct packed {
      logic [16:0] curve_value;
      logic        was_write;
   } rsp_type;

   // one breakpoint as stored in the table
   typedef struct packed {
      logic signed [31:0] x;
      logic [16:0]        y;
      logic [2:0]         mode;
      logic signed [11:0] tweak;
   } entry_type;

   typedef struct packed {
      logic        start;
      logic [47:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [17:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic        start;
      logic [16:0] base;
      logic [11:0] expo;
   } pow_req_type;

   typedef struct packed {
      logic        done;
      logic [16:0] result;
   } pow_rsp_type;

   // Q16 value of 2^(2^-(k+1)) for the fractional exp2 product chain
   function automatic logic [16:0] exp2_tab(input logic [3:0] k);
      logic [16:0] v;
      unique case (k)
         4'd0:  v = 17'd92682;
         4'd1:  v = 17'd77936;
         4'd2:  v = 17'd71468;
         4'd3:  v = 17'd68438;
         4'd4:  v = 17'd66971;
         4'd5:  v = 17'd66250;
         4'd6:  v = 17'd65892;
         4'd7:  v = 17'd65714;
         4'd8:  v = 17'd65625;
         4'd9:  v = 17'd65580;
         4'd10: v = 17'd65558;
         4'd11: v = 17'd65547;
         4'd12: v = 17'd65542;
         4'd13: v = 17'd65539;
         4'd14: v = 17'd65537;
         4'd15: v = 17'd65537;
      endcase
      return v;
   endfunction

   // (hi + 1) times 0.99999 in Q20; hi is the integer part of |tweak|
   function automatic logic [23:0] cq_of(input logic [3:0] hi);
      logic [23:0] v;
      unique case (hi)
         4'd0:    v = 24'd1048566;
         4'd1:    v = 24'd2097132;
         4'd2:    v = 24'd3145698;
         4'd3:    v = 24'd4194264;
         4'd4:    v = 24'd5242830;
         4'd5:    v = 24'd6291396;
         4'd6:    v = 24'd7339962;
         4'd7:    v = 24'd8388528;
         4'd8:    v = 24'd9437094;
         default: v = 24'd9437094;
      endcase
      return v;
   endfunction

endpackage

// ----- rtl/pwenv_div.sv -----
// Restoring divider, one quotient bit per cycle, 18 quotient bits.
// Depends on pwenv_pkg; caller guarantees dividend[47:18] < divisor.
module pwenv_div (
   input  logic                      clock,
   input  logic                      reset,
   input  pwenv_pkg::div_req_type    div_req,
   output pwenv_pkg::div_rsp_type    div_rsp
);

   logic [31:0] rem_ff;
   logic [31:0] dsr_ff;
   logic [17:0] shf_ff;
   logic [4:0]  cnt_ff;
   logic        busy_ff;
   logic        done_ff;

   logic [32:0] trial;
   logic        fits;

   // one restoring step
   always_comb begin
      trial = {rem_ff, shf_ff[17]};
      fits  = (trial >= {1'b0, dsr_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         // done pulses after the last quotient bit
         done_ff <= busy_ff && !div_req.start && (cnt_ff == 5'd17);
         if (div_req.start) begin
            rem_ff  <= {2'b00, div_req.dividend[47:18]};
            shf_ff  <= div_req.dividend[17:0];
            dsr_ff  <= div_req.divisor;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= fits ? 32'(trial - {1'b0, dsr_ff}) : trial[31:0];
            shf_ff <= {shf_ff[16:0], fits};
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd17) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = shf_ff;

endmodule

// ----- rtl/pwenv_pow.sv -----
// Fixed-point power unit: base^(2^(expo/256)) via iterative log2 and exp2.
// Depends on pwenv_pkg for the exp2 table and the request/response structs.
module pwenv_pow (
   input  logic                      clock,
   input  logic                      reset,
   input  pwenv_pkg::pow_req_type    pow_req,
   output pwenv_pkg::pow_rsp_type    pow_rsp
);

   typedef enum logic [2:0] {
      P_IDLE, P_LOG, P_EXP1, P_MUL, P_CHK, P_EXP2
   } pstate_type;

   pstate_type  state_ff;
   logic [15:0] m_ff;
   logic [15:0] f_ff;
   logic [4:0]  lz_ff;
   logic [3:0]  k_ff;
   logic [16:0] acc_ff;
   logic [15:0] g_ff;
   logic [3:0]  sh_ff;
   logic [29:0] ylog_ff;
   logic        done_ff;
   logic [16:0] result_ff;

   logic [3:0]  lead;
   logic [15:0] m_init;
   logic [31:0] sq;
   logic [16:0] sqs;
   logic [33:0] exp_prod;
   logic [16:0] exp_next;
   logic [20:0] nl;
   logic [37:0] mul_prod;
   logic [29:0] ylog_in;
   logic        too_big;
   logic [4:0]  nsh;
   logic        done_in;

   // leading one of the base and its normalized mantissa
   always_comb begin
      lead = '0;
      for (int i = 0; i < 16; i++) begin
         if (pow_req.base[i]) lead = 4'(i);
      end
      m_init = 16'(pow_req.base[15:0] << (4'd15 - lead));
   end

   // datapath for log squaring, exp2 product chain and scaled log
   always_comb begin
      sq       = m_ff * m_ff;
      sqs      = sq[31:15];
      exp_prod = acc_ff * pwenv_pkg::exp2_tab(k_ff);
      exp_next = g_ff[~k_ff] ? exp_prod[32:16] : acc_ff;
      nl       = 21'({lz_ff, 16'h0000}) - 21'(f_ff);
      mul_prod = nl * acc_ff;
      ylog_in  = 30'(mul_prod[37:16]) << sh_ff;
      too_big  = (ylog_ff[29:16] >= 14'd17);
      nsh      = ylog_ff[20:16];
   end

   // result is ready: trivial base, early exit or last exp2 step
   always_comb begin
      done_in = ((state_ff == P_IDLE) && pow_req.start &&
                 ((pow_req.base == 17'd0) || pow_req.base[16])) ||
                ((state_ff == P_CHK) && (too_big || (ylog_ff[15:0] == 16'h0000))) ||
                ((state_ff == P_EXP2) && (k_ff == 4'd15));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= P_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= done_in;
         unique case (state_ff)
            P_IDLE: begin
               if (pow_req.start) begin
                  if (pow_req.base == 17'd0) begin
                     result_ff <= '0;
                  end else if (pow_req.base[16]) begin
                     result_ff <= pwenv_pkg::Q_ONE;
                  end else begin
                     m_ff     <= m_init;
                     lz_ff    <= 5'd16 - 5'(lead);
                     f_ff     <= '0;
                     k_ff     <= '0;
                     sh_ff    <= pow_req.expo[11:8];
                     g_ff     <= {pow_req.expo[7:0], 8'h00};
                     state_ff <= P_LOG;
                  end
               end
            end
            // one log2 fraction bit per cycle
            P_LOG: begin
               f_ff <= {f_ff[14:0], sqs[16]};
               m_ff <= sqs[16] ? sqs[16:1] : sqs[15:0];
               k_ff <= k_ff + 4'd1;
               if (k_ff == 4'd15) begin
                  acc_ff   <= pwenv_pkg::Q_ONE;
                  state_ff <= P_EXP1;
               end
            end
            P_EXP1: begin
               acc_ff <= exp_next;
               k_ff   <= k_ff + 4'd1;
               if (k_ff == 4'd15) state_ff <= P_MUL;
            end
            P_MUL: begin
               ylog_ff  <= ylog_in;
               state_ff <= P_CHK;
            end
            P_CHK: begin
               if (too_big) begin
                  result_ff <= '0;
                  state_ff  <= P_IDLE;
               end else if (ylog_ff[15:0] == 16'h0000) begin
                  result_ff <= pwenv_pkg::Q_ONE >> nsh;
                  state_ff  <= P_IDLE;
               end else begin
                  acc_ff   <= pwenv_pkg::Q_ONE;
                  g_ff     <= 16'(pwenv_pkg::Q_ONE - {1'b0, ylog_ff[15:0]});
                  k_ff     <= '0;
                  state_ff <= P_EXP2;
               end
            end
            P_EXP2: begin
               acc_ff <= exp_next;
               k_ff   <= k_ff + 4'd1;
               if (k_ff == 4'd15) begin
                  result_ff <= (exp_next >> 1) >> nsh;
                  state_ff  <= P_IDLE;
               end
            end
            default: state_ff <= P_IDLE;
         endcase
      end
   end

   assign pow_rsp.done   = done_ff;
   assign pow_rsp.result = result_ff;

endmodule

// ----- rtl/piecewise_envelope_evaluator_top.sv -----
// Top level of the piecewise envelope evaluator: breakpoint memory, scan sequencer,
// segment shaping and interpolation. Depends on pwenv_pkg, pwenv_div and pwenv_pow.
//
// Usage:
//   req channel (req_valid/req_stall/req_data) carries one request per accept.
//   A write request stores one breakpoint and returns a response with was_write set.
//   An evaluate request returns the curve value at sample_time.
//   rsp channel (rsp_valid/rsp_stall/rsp_data) holds one response in an output
//   register; the receiver stalls it as long as it likes.
//   csr channel (csr_valid/csr_ready/csr_data) sets point_count; ready is always high.
// Sequencing:
//   One request at a time. A write goes straight from idle to S_DONE. An evaluation
//   scans the table one entry per cycle through the memory's registered read port,
//   then runs a divide, the shaping step (power curves use the power unit, steps a
//   second divide) and the two interpolation multiplies.
//   req_stall is low only when the sequencer is idle; a finished response may sit
//   in the output register while the next request is accepted.
// Reset: synchronous, clears point_count and the sequencer; the table is undefined
//   until written.
module piecewise_envelope_evaluator_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  pwenv_pkg::req_type   req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pwenv_pkg::rsp_type   rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [6:0]           csr_data
);

   typedef enum logic [3:0] {
      S_IDLE, S_FIRST, S_SCAN, S_QDIV, S_SHAPE, S_SAW, S_STEP, S_SDIV,
      S_POW, S_MIX1, S_MIX2, S_DONE
   } state_type;

   state_type                 state_ff;
   logic [6:0]                count_ff;
   logic                      rsp_valid_ff;
   pwenv_pkg::rsp_type        rsp_data_ff;
   logic signed [31:0]        t_ff;
   pwenv_pkg::entry_type      prev_ff;
   pwenv_pkg::entry_type      cur_ff;
   logic [5:0]                idx_ff;
   logic [16:0]               q_ff;
   logic [16:0]               res_ff;
   logic                      wr_ff;
   logic [40:0]               prod_ff;
   logic [33:0]               mix_ff;

   pwenv_pkg::entry_type      table_mem [pwenv_pkg::MAX_POINTS];
   pwenv_pkg::entry_type      rd_data_ff;
   logic [5:0]                rd_addr;
   logic                      mem_we;
   pwenv_pkg::entry_type      wr_entry;

   pwenv_pkg::div_req_type    div_req;
   pwenv_pkg::div_rsp_type    div_rsp;
   pwenv_pkg::pow_req_type    pow_req;
   pwenv_pkg::pow_rsp_type    pow_rsp;

   logic [6:0]                n_eff;
   logic                      scan_hit;
   logic                      first_le;
   logic [32:0]               num;
   logic [32:0]               den;
   logic [11:0]               mag;
   logic [23:0]               cq;
   logic [23:0]               cq1;
   logic [17:0]               q2;
   logic [16:0]               arg_x;
   logic [16:0]               pcurve;
   logic [16:0]               q_div;
   logic [16:0]               saw_v;
   logic [4:0]                step_n;
   logic [5:0]                step_n1;
   logic [33:0]               mix2;
   logic [34:0]               vsum;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   // table write from an accepted write request, value saturated to one
   always_comb begin
      mem_we         = (state_ff == S_IDLE) && req_valid &&
                       (req_data.command == pwenv_pkg::CMD_WRITE);
      wr_entry.x     = req_data.point_x;
      wr_entry.y     = (req_data.point_y > pwenv_pkg::Q_ONE) ? pwenv_pkg::Q_ONE
                                                              : req_data.point_y;
      wr_entry.mode  = req_data.point_mode;
      wr_entry.tweak = req_data.point_tweak;
   end

   // read address runs one entry ahead of the scan
   always_comb begin
      unique case (state_ff)
         S_FIRST: rd_addr = 6'd1;
         S_SCAN:  rd_addr = idx_ff + 6'd1;
         default: rd_addr = 6'd0;
      endcase
   end

   // breakpoint memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) table_mem[req_data.point_index] <= wr_entry;
      rd_data_ff <= table_mem[rd_addr];
   end

   // scan compares, segment span and shaping operands
   always_comb begin
      n_eff    = (count_ff > 7'(pwenv_pkg::MAX_POINTS)) ? 7'(pwenv_pkg::MAX_POINTS)
                                                         : count_ff;
      first_le = ($signed(t_ff) <= $signed(rd_data_ff.x));
      scan_hit = ($signed(rd_data_ff.x) >= $signed(t_ff));
      num      = {t_ff[31], t_ff} - {prev_ff.x[31], prev_ff.x};
      den      = {rd_data_ff.x[31], rd_data_ff.x} - {prev_ff.x[31], prev_ff.x};
      mag      = cur_ff.tweak[11] ? 12'(~cur_ff.tweak + 12'd1) : cur_ff.tweak;
      cq       = pwenv_pkg::cq_of(mag[11:8]);
      cq1      = cq + 24'h100000;
      q2       = {q_ff, 1'b0};
      if (cur_ff.mode == pwenv_pkg::MODE_SINGLE) begin
         arg_x = q_ff;
      end else if (q2 > 18'(pwenv_pkg::Q_ONE)) begin
         arg_x = 17'(q2 - 18'(pwenv_pkg::Q_ONE));
      end else begin
         arg_x = 17'(18'(pwenv_pkg::Q_ONE) - q2);
      end
      pcurve   = cur_ff.tweak[11] ? pow_rsp.result : pwenv_pkg::Q_ONE - pow_rsp.result;
      q_div    = (div_rsp.quotient > 18'(pwenv_pkg::Q_ONE)) ? pwenv_pkg::Q_ONE
                                                            : div_rsp.quotient[16:0];
      saw_v    = {1'b0, prod_ff[35:20]};
      if (cur_ff.tweak[11]) saw_v = pwenv_pkg::Q_ONE - saw_v;
      if (cur_ff.mode == pwenv_pkg::MODE_PULSE) begin
         saw_v = (saw_v > pwenv_pkg::Q_HALF) ? pwenv_pkg::Q_ONE : 17'd0;
      end
      step_n   = prod_ff[40:36];
      step_n1  = 6'(step_n) + 6'd1;
      mix2     = cur_ff.y * q_ff;
      vsum     = 35'(mix_ff) + 35'(mix2) + 35'd32768;
   end

   // divider and power unit requests
   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = {num[31:0], 16'h0000};
      div_req.divisor  = den[31:0];
      if (state_ff == S_SCAN && scan_hit) begin
         div_req.start = 1'b1;
      end else if (state_ff == S_STEP) begin
         div_req.start = 1'b1;
         if (!cur_ff.tweak[11]) begin
            div_req.dividend = {7'b0, step_n, 36'b0};
            div_req.divisor  = {8'b0, cq};
         end else begin
            div_req.dividend = {6'b0, step_n1, 36'b0};
            div_req.divisor  = {8'b0, cq1};
         end
      end
      pow_req.start = (state_ff == S_SHAPE) &&
                      ((cur_ff.mode == pwenv_pkg::MODE_SINGLE) ||
                       ((cur_ff.mode == pwenv_pkg::MODE_DOUBLE) &&
                        (q2 != 18'(pwenv_pkg::Q_ONE))));
      pow_req.base  = cur_ff.tweak[11] ? arg_x : pwenv_pkg::Q_ONE - arg_x;
      pow_req.expo  = mag;
   end

   pwenv_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   pwenv_pow u_pow (
      .clock   (clock),
      .reset   (reset),
      .pow_req (pow_req),
      .pow_rsp (pow_rsp)
   );

   // sequencer, config register and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) count_ff <= csr_data;
         // drained response; S_DONE reloads the register itself
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  if (req_data.command == pwenv_pkg::CMD_WRITE) begin
                     res_ff   <= '0;
                     wr_ff    <= 1'b1;
                     state_ff <= S_DONE;
                  end else begin
                     t_ff  <= req_data.sample_time;
                     wr_ff <= 1'b0;
                     if (n_eff == 7'd0) begin
                        res_ff   <= '0;
                        state_ff <= S_DONE;
                     end else begin
                        state_ff <= S_FIRST;
                     end
                  end
               end
            end
            // first entry: clamp before the curve
            S_FIRST: begin
               prev_ff <= rd_data_ff;
               idx_ff  <= 6'd1;
               if (first_le || n_eff == 7'd1) begin
                  res_ff   <= rd_data_ff.y;
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_SCAN;
               end
            end
            // linear search for the segment end
            S_SCAN: begin
               if (scan_hit) begin
                  cur_ff   <= rd_data_ff;
                  state_ff <= S_QDIV;
               end else begin
                  prev_ff <= rd_data_ff;
                  idx_ff  <= idx_ff + 6'd1;
                  if (7'(idx_ff) == n_eff - 7'd1) begin
                     res_ff   <= rd_data_ff.y;
                     state_ff <= S_DONE;
                  end
               end
            end
            S_QDIV: begin
               if (div_rsp.done) begin
                  q_ff     <= q_div;
                  state_ff <= S_SHAPE;
               end
            end
            // mode dispatch on the segment end point
            S_SHAPE: begin
               unique case (cur_ff.mode)
                  pwenv_pkg::MODE_HOLD: begin
                     q_ff     <= '0;
                     state_ff <= S_MIX1;
                  end
                  pwenv_pkg::MODE_SINGLE: state_ff <= S_POW;
                  pwenv_pkg::MODE_DOUBLE: begin
                     if (q2 == 18'(pwenv_pkg::Q_ONE)) begin
                        q_ff     <= pwenv_pkg::Q_HALF;
                        state_ff <= S_MIX1;
                     end else begin
                        state_ff <= S_POW;
                     end
                  end
                  pwenv_pkg::MODE_SAW, pwenv_pkg::MODE_PULSE: begin
                     prod_ff  <= q_ff * cq;
                     state_ff <= S_SAW;
                  end
                  pwenv_pkg::MODE_STEPS: begin
                     prod_ff  <= q_ff * (cur_ff.tweak[11] ? cq : cq1);
                     state_ff <= S_STEP;
                  end
                  default: state_ff <= S_MIX1;
               endcase
            end
            S_SAW: begin
               q_ff     <= saw_v;
               state_ff <= S_MIX1;
            end
            S_STEP: state_ff <= S_SDIV;
            S_SDIV: begin
               if (div_rsp.done) begin
                  q_ff     <= q_div;
                  state_ff <= S_MIX1;
               end
            end
            S_POW: begin
               if (pow_rsp.done) begin
                  if (cur_ff.mode == pwenv_pkg::MODE_SINGLE) begin
                     q_ff <= pcurve;
                  end else if (q2 > 18'(pwenv_pkg::Q_ONE)) begin
                     q_ff <= pwenv_pkg::Q_HALF + (pcurve >> 1);
                  end else begin
                     q_ff <= pwenv_pkg::Q_HALF - (pcurve >> 1);
                  end
                  state_ff <= S_MIX1;
               end
            end
            // interpolation, one product per cycle
            S_MIX1: begin
               mix_ff   <= prev_ff.y * (pwenv_pkg::Q_ONE - q_ff);
               state_ff <= S_MIX2;
            end
            S_MIX2: begin
               res_ff   <= vsum[32:16];
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff            <= 1'b1;
                  rsp_data_ff.curve_value <= res_ff;
                  rsp_data_ff.was_write   <= wr_ff;
                  state_ff                <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
